[rtl/ecct_pkg.sv]
// ----------------------------------------------------------------------------
// ecct_pkg
// Types and constants shared by the confirmation and cooldown table.
// ----------------------------------------------------------------------------
package ecct_pkg;
    localparam int ENTRIES    = 64;
    localparam int TRACK_BITS = 16;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int CMD_IN_W   = 2 + TRACK_BITS + 4 + 32;

    localparam logic [IDX_BITS-1:0] LAST_POS = IDX_BITS'(ENTRIES - 1);

    localparam logic [15:0] PENDING_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_CAND  = 2'd0,
        OP_SEEN  = 2'd1,
        OP_FRAME = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    localparam logic REG_CONFIRM  = 1'b0;
    localparam logic REG_COOLDOWN = 1'b1;

    typedef struct packed {
        logic             [1:0] op;
        logic [TRACK_BITS-1:0]  track;
        logic             [3:0] kind;
        logic            [31:0] now;
        logic            [15:0] confirm;
        logic            [31:0] cooldown;
    } t_cmd;

    // Token that travels down the row of cells.
    typedef struct packed {
        logic                   hit;
        logic                   free_found;
        logic                   emit;
        logic                   status;
    } t_token;
endpackage

[rtl/ecct_if.sv]
// ----------------------------------------------------------------------------
// ecct_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface ecct_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ecct_cell.sv]
// ----------------------------------------------------------------------------
// ecct_cell
// One table entry; acts on the command when the travelling token reaches it.
// ----------------------------------------------------------------------------
module ecct_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic            i_act,
    input  ecct_pkg::t_cmd  i_cmd,
    input  ecct_pkg::t_token i_tok,
    input  logic            i_hit_later,
    output ecct_pkg::t_token o_tok
);
    import ecct_pkg::*;

    logic                  r_valid;
    logic [TRACK_BITS-1:0] r_track;
    logic [3:0]            r_kind;
    logic [15:0]           r_pend;
    logic                  r_logged;
    logic [31:0]           r_last;
    logic                  r_seen;

    logic        match;
    logic        take;
    logic        use_it;
    logic [15:0] pend_in;
    logic [15:0] pend_inc;
    logic        cool_ok;
    logic        fire;

    assign match   = r_valid && r_track == i_cmd.track && r_kind == i_cmd.kind;
    // A free slot is taken only if no later cell holds the key.
    assign take    = !r_valid && !i_tok.hit && !i_tok.free_found && !i_hit_later;
    assign use_it  = (match && !i_tok.hit) || take;
    assign pend_in = take ? 16'd0 : r_pend;
    assign pend_inc = (pend_in < PENDING_MAX) ? pend_in + 16'd1 : pend_in;
    assign cool_ok = take || !r_logged || (i_cmd.now - r_last) >= i_cmd.cooldown;
    assign fire    = pend_inc >= i_cmd.confirm && cool_ok;

    always_comb begin
        o_tok = i_tok;
        if (i_cmd.op == OP_CAND) begin
            if (match) o_tok.hit = 1'b1;
            if (!r_valid) o_tok.free_found = 1'b1;
            if (use_it) begin
                o_tok.hit    = 1'b1;
                o_tok.emit   = fire;
                o_tok.status = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid  <= 1'b0;
            r_pend   <= '0;
            r_logged <= 1'b0;
            r_seen   <= 1'b0;
        end else if (i_act) begin
            unique case (t_op'(i_cmd.op))
                OP_CAND: begin
                    if (use_it && i_cmd.op == OP_CAND) begin
                        r_valid <= 1'b1;
                        if (take) begin
                            r_track <= i_cmd.track;
                            r_kind  <= i_cmd.kind;
                            r_seen  <= 1'b0;
                        end
                        if (fire) begin
                            r_pend   <= '0;
                            r_logged <= 1'b1;
                            r_last   <= i_cmd.now;
                        end else begin
                            r_pend   <= pend_inc;
                            if (take) r_logged <= 1'b0;
                        end
                    end
                end
                OP_SEEN: begin
                    if (r_valid && r_track == i_cmd.track) r_seen <= 1'b1;
                end
                OP_FRAME: begin
                    if (r_valid && !r_seen) r_pend <= '0;
                    r_seen <= 1'b0;
                end
                OP_CLEAR: begin
                    r_valid  <= 1'b0;
                    r_pend   <= '0;
                    r_logged <= 1'b0;
                    r_seen   <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule

[rtl/ecct_row.sv]
// ----------------------------------------------------------------------------
// ecct_row
// Row of cells; the token steps one cell per cycle, then the result is formed.
// ----------------------------------------------------------------------------
module ecct_row (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ecct_pkg::t_cmd   i_cmd,
    output logic             o_done,
    output ecct_pkg::t_token o_tok
);
    import ecct_pkg::*;

    logic [IDX_BITS-1:0] r_pos;
    logic                r_busy;
    logic                r_pass;
    t_token              r_tok;
    t_token              tok_out [ENTRIES];
    logic [ENTRIES-1:0]  act;

    // For a candidate, the first pass finds whether the key exists anywhere; the second pass updates.
    logic                r_found;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            assign act[g] = r_busy && r_pass && r_pos == IDX_BITS'(g);
            ecct_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_clr      (1'b0),
                .i_act      (act[g]),
                .i_cmd      (i_cmd),
                .i_tok      (r_tok),
                .i_hit_later(!r_pass || r_found),
                .o_tok      (tok_out[g])
            );
        end
    endgenerate

    t_token cur;
    t_token fin;
    assign cur = tok_out[r_pos];

    always_comb begin
        fin = cur;
        if (i_cmd.op == OP_CAND && !cur.hit) begin
            fin.emit   = 1'b1;
            fin.status = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_pass <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_pos   <= '0;
                r_pass  <= i_cmd.op != OP_CAND;
                r_tok   <= '0;
                r_found <= 1'b0;
            end else if (r_busy) begin
                if (r_pos == LAST_POS) begin
                    r_pos <= '0;
                    if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_found <= cur.hit;
                        r_tok   <= '0;
                    end else begin
                        r_busy <= 1'b0;
                        o_done <= 1'b1;
                        o_tok  <= fin;
                    end
                end else begin
                    r_pos <= r_pos + IDX_BITS'(1);
                    r_tok <= cur;
                end
            end
        end
    end
endmodule

[rtl/event_confirm_cooldown_table_core.sv]
// ----------------------------------------------------------------------------
// event_confirm_cooldown_table_core
// A candidate request walks the row of cells twice, a key search and then the
// update, and its result is registered when the second walk ends. Other
// requests walk the row once. No new request is taken while one is walking
// the row, and a waiting result holds off new requests until it is taken.
// Reset is synchronous: table empty, confirm count 3, cooldown 5000.
// ----------------------------------------------------------------------------
module event_confirm_cooldown_table_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    ecct_stream_if.sink   in_if,
    ecct_stream_if.source out_if
);
    import ecct_pkg::*;

    logic [15:0]           r_confirm;
    logic [31:0]           r_cooldown;
    logic                  r_busy;
    t_cmd                  r_cmd;
    t_cmd                  cmd_in;
    logic                  start;
    logic                  done;
    t_token                tok;
    logic                  r_ov;
    logic [TRACK_BITS+4:0] r_od;

    assign in_if.ready = !r_busy && !r_ov;
    assign start = in_if.valid && in_if.ready;
    assign cmd_in = t_cmd'({in_if.data[CMD_IN_W-1:0], r_confirm, r_cooldown});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm  <= 16'd3;
            r_cooldown <= 32'd5000;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_CONFIRM) r_confirm <= i_cfg_data[15:0];
            else r_cooldown <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (start) begin
                r_busy <= 1'b1;
                r_cmd  <= cmd_in;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done && tok.emit) begin
                r_ov <= 1'b1;
                r_od <= {r_cmd.track, r_cmd.kind, tok.status};
            end else if (out_if.valid && out_if.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    ecct_row u_row (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_cmd  (start ? cmd_in : r_cmd),
        .o_done (done),
        .o_tok  (tok)
    );

    assign out_if.valid = r_ov;
    assign out_if.data  = r_od;
endmodule

[rtl/ecct_checker.sv]
// ----------------------------------------------------------------------------
// ecct_checker
// Port-level checks on the confirmation table.
// ----------------------------------------------------------------------------
module ecct_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    a_noacc_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result lost");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second request taken");
endmodule

bind event_confirm_cooldown_table_core ecct_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the confirmation and cooldown table. Requests are
// sent on the input channel, a scoreboard predicts each result from its own
// copy of the table, and every result on the output channel is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import ecct_pkg::*;

    localparam int IN_W    = 2 + TRACK_BITS + 4 + 32;
    localparam int OUT_W   = TRACK_BITS + 4 + 1;
    localparam int SLOTS   = ENTRIES;
    localparam int SETTLE  = 2 * ENTRIES + 16;
    localparam int LIMIT   = 2000000;

    typedef struct packed {
        logic [TRACK_BITS-1:0] track;
        logic            [3:0] kind;
        logic                  status;
    } t_verdict;

    class cooldown_scoreboard;
        bit                  used [SLOTS];
        bit [TRACK_BITS-1:0] trk [SLOTS];
        bit            [3:0] knd [SLOTS];
        bit           [15:0] pend [SLOTS];
        bit                  logged [SLOTS];
        bit           [31:0] last [SLOTS];
        bit                  seen [SLOTS];
        bit           [15:0] confirm_cnt = 16'd3;
        bit           [31:0] cooldown = 32'd5000;
        t_verdict            pending_verdicts [$];
        int                  mismatches = 0;

        function void empty_table();
            for (int i = 0; i < SLOTS; i++) begin
                used[i] = 0; pend[i] = 0; logged[i] = 0; seen[i] = 0;
            end
        endfunction

        function void note_request(logic [IN_W-1:0] req);
            logic            [1:0] op;
            logic [TRACK_BITS-1:0] track;
            logic            [3:0] kind;
            logic           [31:0] now;
            int                    hit;
            int                    free_slot;
            t_verdict              v;
            {op, track, kind, now} = req;
            hit = -1;
            free_slot = -1;
            case (op)
                OP_CAND: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (used[i]) begin
                            if (hit < 0 && trk[i] == track && knd[i] == kind) hit = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    v.track = track;
                    v.kind = kind;
                    if (hit < 0) begin
                        if (free_slot < 0) begin
                            v.status = 1'b1;
                            pending_verdicts = {pending_verdicts, v};
                            return;
                        end
                        hit = free_slot;
                        used[hit] = 1; trk[hit] = track; knd[hit] = kind;
                        pend[hit] = 0; logged[hit] = 0; last[hit] = 0; seen[hit] = 0;
                    end
                    if (pend[hit] != PENDING_MAX) pend[hit]++;
                    if (pend[hit] < confirm_cnt) return;
                    if (logged[hit] && (now - last[hit]) < cooldown) return;
                    last[hit] = now;
                    logged[hit] = 1;
                    pend[hit] = 0;
                    v.status = 1'b0;
                    pending_verdicts = {pending_verdicts, v};
                end
                OP_SEEN: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (used[i] && trk[i] == track) seen[i] = 1;
                end
                OP_FRAME: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (used[i] && !seen[i]) pend[i] = 0;
                        seen[i] = 0;
                    end
                end
                default: empty_table();
            endcase
        endfunction

        function void check_result(logic [OUT_W-1:0] res);
            t_verdict got;
            t_verdict want;
            got = res;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: track %h kind %h status %b",
                             got.track, got.kind, got.status);
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.track !== want.track || got.kind !== want.kind
                || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h/%h/%b, got %h/%h/%b",
                             want.track, want.kind, want.status,
                             got.track, got.kind, got.status);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_CONFIRM;
    logic [31:0] i_cfg_data = '0;

    ecct_stream_if #(.W(IN_W))  req_if ();
    ecct_stream_if #(.W(OUT_W)) res_if ();

    event_confirm_cooldown_table_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_if      (req_if),
        .out_if     (res_if)
    );

    cooldown_scoreboard sb = new();
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 cycles = 0;
    logic        [31:0] clock_ticks = 32'd0;
    logic [TRACK_BITS-1:0] track_pool [8];

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) sb.check_result(res_if.data);
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(t_op op, logic [TRACK_BITS-1:0] track,
                                logic [3:0] kind, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= {op, track, kind, now};
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request({op, track, kind, now});
    endtask

    task automatic drain_and_configure(logic [15:0] confirm, logic [31:0] cooldown);
        req_if.valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_CONFIRM;
        i_cfg_data <= {16'h0, confirm};
        @(posedge i_clk);
        i_cfg_idx <= REG_COOLDOWN;
        i_cfg_data <= cooldown;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.confirm_cnt = confirm;
        sb.cooldown = cooldown;
    endtask

    task automatic random_request();
        int                    pick;
        logic [TRACK_BITS-1:0] track;
        pick = $urandom_range(99);
        track = track_pool[$urandom_range(7)];
        if ($urandom_range(9) == 0) clock_ticks = $urandom;
        else clock_ticks = clock_ticks + $urandom_range(2 * sb.cooldown[15:0] + 40);
        if (pick < 68)
            send_request(OP_CAND, track, 4'($urandom_range(3)), clock_ticks);
        else if (pick < 82)
            send_request(OP_SEEN, track, 4'($urandom), $urandom);
        else if (pick < 90)
            send_request(OP_FRAME, TRACK_BITS'($urandom), 4'($urandom), $urandom);
        else if (pick < 92)
            send_request(OP_CLEAR, TRACK_BITS'($urandom), 4'($urandom), $urandom);
        else
            send_request(t_op'($urandom_range(1)), TRACK_BITS'($urandom),
                         4'($urandom), $urandom);
    endtask

    initial begin
        logic [15:0] confirms [6] = '{16'd1, 16'd2, 16'd0, 16'd65535, 16'd4, 16'd3};
        logic [31:0] cooldowns [6] = '{32'd0, 32'd100, 32'd50, 32'hFFFF_FFFF,
                                      32'd3000, 32'd5000};
        int          sent;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Confirmation on the third candidate, then a cooldown hold and release.
        repeat (3) send_request(OP_CAND, 16'h0012, 4'h3, 32'd0);
        repeat (3) send_request(OP_CAND, 16'h0012, 4'h3, 32'd100);
        send_request(OP_CAND, 16'h0012, 4'h3, 32'd5100);
        // Present and absent tracks across an end of frame.
        send_request(OP_CAND, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
        send_request(OP_CAND, 16'h0000, 4'h0, 32'h0);
        send_request(OP_SEEN, 16'hFFFF, 4'h0, 32'h0);
        send_request(OP_FRAME, 16'h0, 4'h0, 32'h0);
        send_request(OP_CAND, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
        send_request(OP_CAND, 16'h0000, 4'h0, 32'h0);
        send_request(OP_SEEN, 16'h0BAD, 4'h0, 32'h0);
        send_request(OP_CLEAR, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
        // Fill every slot, then one more key finds the table full.
        for (int i = 0; i < SLOTS; i++)
            send_request(OP_CAND, TRACK_BITS'(16'h0100 + i), 4'(i), 32'd7);
        send_request(OP_CAND, 16'hABCD, 4'h9, 32'd8);
        send_request(OP_CAND, 16'h0100, 4'h0, 32'd9);
        send_request(OP_CLEAR, 16'h0, 4'h0, 32'h0);

        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_configure(confirms[ph], cooldowns[ph]);
            for (int k = 0; k < 8; k++)
                track_pool[k] = (k < 6) ? TRACK_BITS'($urandom_range(15)) :
                                          TRACK_BITS'($urandom);
            for (int n = 0; n < 228; n++) begin
                if (sent < 456) begin
                    send_idle_pct = 22; recv_stall_pct = 82;
                end else if (sent < 912) begin
                    send_idle_pct = 82; recv_stall_pct = 22;
                end else begin
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
                random_request();
                sent++;
            end
        end

        req_if.valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
